// ===== sv/rc4kx_pkg.sv =====
`default_nettype none
package rc4kx_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int TABLE_SIZE    = 256;
    localparam int BYTE_W        = 8;
    localparam int TBL_ADDR_W    = $clog2(TABLE_SIZE);
    localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 1);
    localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int DROP_W        = 16;
    localparam int KLEN_W        = 5;
    localparam int CMD_W         = 2;
    localparam int STAT_W        = 3;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 8;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_KEY_STORED = 3'd0,
        STAT_KEY_FULL   = 3'd1,
        STAT_SCHEDULED  = 3'd2,
        STAT_DATA       = 3'd3,
        STAT_UNKEYED    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_DATA
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [BYTE_W-1:0]     data;
        logic [KEY_CNT_W-1:0]  klen;
        logic [DROP_W-1:0]     drop;
        logic                  fin;
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_KS_RD_N,
        S_KS_RD_J,
        S_KS_WR_N,
        S_KS_WR_J,
        S_PG_RD_I,
        S_PG_RD_J,
        S_PG_WR_I,
        S_PG_WR_J,
        S_PG_RD_T,
        S_PG_OUT,
        S_EMIT
    } t_bstate;

endpackage
`default_nettype wire

// ===== sv/rc4kx_ram.sv =====
`default_nettype none
module rc4kx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/rc4kx_front.sv =====
`default_nettype none
module rc4kx_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [rc4kx_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [rc4kx_pkg::CMD_W-1:0]      i_s_tuser,
    input  wire logic                             i_s_tlast,
    output logic                                  o_q_valid,
    input  wire logic                             i_q_ready,
    output rc4kx_pkg::t_op                        o_q_op
);

    localparam int KLEN_LO = rc4kx_pkg::BYTE_W;
    localparam int DROP_LO = KLEN_LO + rc4kx_pkg::KLEN_W;

    rc4kx_pkg::t_op                     r_q [rc4kx_pkg::Q_DEPTH];
    logic [rc4kx_pkg::Q_PTR_W-1:0]      r_wp;
    logic [rc4kx_pkg::Q_PTR_W-1:0]      r_rp;
    logic [rc4kx_pkg::Q_CNT_W-1:0]      r_cnt;

    rc4kx_pkg::t_op                     w_op;
    logic                               w_keep;
    logic [rc4kx_pkg::KLEN_W-1:0]       w_klen_raw;
    logic                               w_push;
    logic                               w_pop;

    function automatic logic [rc4kx_pkg::Q_PTR_W-1:0] ptr_next(
        input logic [rc4kx_pkg::Q_PTR_W-1:0] p
    );
        if (32'(p) == rc4kx_pkg::Q_DEPTH - 1) begin
            return '0;
        end
        return rc4kx_pkg::Q_PTR_W'(32'(p) + 1);
    endfunction

    assign w_klen_raw = i_s_tdata[DROP_LO-1:KLEN_LO];

    // classify the command and clamp the key length
    always_comb begin
        w_op.data = i_s_tdata[rc4kx_pkg::BYTE_W-1:0];
        w_op.drop = i_s_tdata[DROP_LO+rc4kx_pkg::DROP_W-1:DROP_LO];
        w_op.fin  = i_s_tlast;
        if (w_klen_raw == '0) begin
            w_op.klen = rc4kx_pkg::KEY_CNT_W'(1);
        end else if (32'(w_klen_raw) > 32'(rc4kx_pkg::MAX_KEY_BYTES)) begin
            w_op.klen = rc4kx_pkg::KEY_CNT_W'(rc4kx_pkg::MAX_KEY_BYTES);
        end else begin
            w_op.klen = rc4kx_pkg::KEY_CNT_W'(w_klen_raw);
        end
        w_keep    = 1'b1;
        w_op.kind = rc4kx_pkg::OP_DATA;
        unique case (rc4kx_pkg::t_cmd'(i_s_tuser))
            rc4kx_pkg::CMD_LOAD:  w_op.kind = rc4kx_pkg::OP_LOAD;
            rc4kx_pkg::CMD_START: w_op.kind = rc4kx_pkg::OP_START;
            rc4kx_pkg::CMD_DATA:  w_op.kind = rc4kx_pkg::OP_DATA;
            default:              w_keep    = 1'b0;
        endcase
    end

    assign o_s_tready = (32'(r_cnt) != rc4kx_pkg::Q_DEPTH);
    assign w_push     = i_s_tvalid && o_s_tready && w_keep;
    assign o_q_valid  = (r_cnt != '0);
    assign w_pop      = o_q_valid && i_q_ready;
    assign o_q_op     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ptr_next(r_wp);
            end
            if (w_pop) begin
                r_rp <= ptr_next(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + rc4kx_pkg::Q_CNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - rc4kx_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rc4kx_back.sv =====
`default_nettype none
module rc4kx_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_q_valid,
    output logic                                  o_q_ready,
    input  wire rc4kx_pkg::t_op                   i_q_op,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [rc4kx_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic [rc4kx_pkg::STAT_W-1:0]          o_m_tuser,
    output logic                                  o_m_tlast
);

    localparam int BW = rc4kx_pkg::BYTE_W;
    localparam int AW = rc4kx_pkg::TBL_ADDR_W;

    rc4kx_pkg::t_bstate                 r_state;
    rc4kx_pkg::t_bstate                 n_state;
    rc4kx_pkg::t_op                     r_op;
    logic [AW-1:0]                      r_i, n_i;
    logic [AW-1:0]                      r_j, n_j;
    logic [AW-1:0]                      r_n, n_n;
    logic [BW-1:0]                      r_a, n_a;
    logic [BW-1:0]                      r_b, n_b;
    logic [rc4kx_pkg::KEY_IDX_W-1:0]    r_k, n_k;
    logic [rc4kx_pkg::DROP_W-1:0]       r_cnt, n_cnt;
    logic [rc4kx_pkg::KEY_CNT_W-1:0]    r_fill, n_fill;
    logic                               r_keyed, n_keyed;
    logic [BW-1:0]                      r_key [rc4kx_pkg::MAX_KEY_BYTES];
    logic [BW-1:0]                      r_res_byte, n_res_byte;
    rc4kx_pkg::t_status                 r_res_stat, n_res_stat;
    logic                               r_res_last, n_res_last;
    logic                               r_ovalid, n_ovalid;
    logic [BW-1:0]                      r_obyte, n_obyte;
    rc4kx_pkg::t_status                 r_ostat, n_ostat;
    logic                               r_olast, n_olast;

    logic                               w_key_we;
    logic                               w_pop;
    logic                               w_out_free;
    logic                               w_full;
    logic                               w_tbl_last;
    logic                               w_drop_last;
    logic                               w_ram_we;
    logic [AW-1:0]                      w_ram_addr;
    logic [BW-1:0]                      w_ram_wdata;
    logic [BW-1:0]                      w_ram_rdata;
    logic [rc4kx_pkg::KEY_CNT_W-1:0]    w_k_inc;

    rc4kx_ram #(
        .WIDTH (BW),
        .DEPTH (rc4kx_pkg::TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign o_q_ready   = (r_state == rc4kx_pkg::S_IDLE);
    assign w_pop       = i_q_valid && o_q_ready;
    assign w_out_free  = !r_ovalid || i_m_tready;
    assign w_full      = (r_fill == rc4kx_pkg::KEY_CNT_W'(rc4kx_pkg::MAX_KEY_BYTES));
    assign w_tbl_last  = (r_n == '1);
    assign w_drop_last = (r_cnt == rc4kx_pkg::DROP_W'(1));
    assign w_k_inc     = rc4kx_pkg::KEY_CNT_W'(r_k) + rc4kx_pkg::KEY_CNT_W'(1);

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc4kx_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_op.kind)
                        rc4kx_pkg::OP_START: n_state = rc4kx_pkg::S_INIT;
                        rc4kx_pkg::OP_DATA:  n_state = r_keyed ? rc4kx_pkg::S_PG_RD_I
                                                               : rc4kx_pkg::S_EMIT;
                        default:             n_state = rc4kx_pkg::S_EMIT;
                    endcase
                end
            end
            rc4kx_pkg::S_INIT:    if (w_tbl_last) n_state = rc4kx_pkg::S_KS_RD_N;
            rc4kx_pkg::S_KS_RD_N: n_state = rc4kx_pkg::S_KS_RD_J;
            rc4kx_pkg::S_KS_RD_J: n_state = rc4kx_pkg::S_KS_WR_N;
            rc4kx_pkg::S_KS_WR_N: n_state = rc4kx_pkg::S_KS_WR_J;
            rc4kx_pkg::S_KS_WR_J: begin
                if (!w_tbl_last) begin
                    n_state = rc4kx_pkg::S_KS_RD_N;
                end else if (r_op.drop != '0) begin
                    n_state = rc4kx_pkg::S_PG_RD_I;
                end else begin
                    n_state = rc4kx_pkg::S_EMIT;
                end
            end
            rc4kx_pkg::S_PG_RD_I: n_state = rc4kx_pkg::S_PG_RD_J;
            rc4kx_pkg::S_PG_RD_J: n_state = rc4kx_pkg::S_PG_WR_I;
            rc4kx_pkg::S_PG_WR_I: n_state = rc4kx_pkg::S_PG_WR_J;
            rc4kx_pkg::S_PG_WR_J: n_state = rc4kx_pkg::S_PG_RD_T;
            rc4kx_pkg::S_PG_RD_T: n_state = rc4kx_pkg::S_PG_OUT;
            rc4kx_pkg::S_PG_OUT: begin
                if (r_op.kind == rc4kx_pkg::OP_START && !w_drop_last) begin
                    n_state = rc4kx_pkg::S_PG_RD_I;
                end else begin
                    n_state = rc4kx_pkg::S_EMIT;
                end
            end
            rc4kx_pkg::S_EMIT:    if (w_out_free) n_state = rc4kx_pkg::S_IDLE;
            default:              n_state = rc4kx_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_keyed     = r_keyed;
        n_res_byte  = r_res_byte;
        n_res_stat  = r_res_stat;
        n_res_last  = r_res_last;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_obyte     = r_obyte;
        n_ostat     = r_ostat;
        n_olast     = r_olast;
        w_key_we    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_addr  = r_n;
        w_ram_wdata = r_n;
        unique case (r_state)
            rc4kx_pkg::S_IDLE: begin
                n_res_byte = '0;
                n_res_last = 1'b0;
                n_n        = '0;
                if (w_pop) begin
                    unique case (i_q_op.kind)
                        rc4kx_pkg::OP_LOAD: begin
                            if (w_full) begin
                                n_res_stat = rc4kx_pkg::STAT_KEY_FULL;
                            end else begin
                                w_key_we   = 1'b1;
                                n_fill     = r_fill + rc4kx_pkg::KEY_CNT_W'(1);
                                n_res_stat = rc4kx_pkg::STAT_KEY_STORED;
                            end
                        end
                        rc4kx_pkg::OP_START: begin
                            n_res_stat = rc4kx_pkg::STAT_SCHEDULED;
                        end
                        default: begin
                            n_res_byte = i_q_op.data;
                            n_res_last = i_q_op.fin;
                            n_res_stat = r_keyed ? rc4kx_pkg::STAT_DATA
                                                 : rc4kx_pkg::STAT_UNKEYED;
                        end
                    endcase
                end
            end
            rc4kx_pkg::S_INIT: begin
                // identity fill
                w_ram_we    = 1'b1;
                n_n         = r_n + AW'(1);
                n_j         = '0;
                n_k         = '0;
            end
            rc4kx_pkg::S_KS_RD_N: begin
                w_ram_addr = r_n;
            end
            rc4kx_pkg::S_KS_RD_J: begin
                n_a        = w_ram_rdata;
                n_j        = AW'(r_j + w_ram_rdata + r_key[r_k]);
                w_ram_addr = n_j;
            end
            rc4kx_pkg::S_KS_WR_N: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_n;
                w_ram_wdata = w_ram_rdata;
            end
            rc4kx_pkg::S_KS_WR_J: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_j;
                w_ram_wdata = r_a;
                n_n         = r_n + AW'(1);
                if (w_k_inc >= r_op.klen) begin
                    n_k = '0;
                end else begin
                    n_k = rc4kx_pkg::KEY_IDX_W'(w_k_inc);
                end
                if (w_tbl_last) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_fill  = '0;
                    n_keyed = 1'b1;
                    n_cnt   = r_op.drop;
                end
            end
            rc4kx_pkg::S_PG_RD_I: begin
                n_i        = r_i + AW'(1);
                w_ram_addr = n_i;
            end
            rc4kx_pkg::S_PG_RD_J: begin
                n_a        = w_ram_rdata;
                n_j        = AW'(r_j + w_ram_rdata);
                w_ram_addr = n_j;
            end
            rc4kx_pkg::S_PG_WR_I: begin
                n_b         = w_ram_rdata;
                w_ram_we    = 1'b1;
                w_ram_addr  = r_i;
                w_ram_wdata = w_ram_rdata;
            end
            rc4kx_pkg::S_PG_WR_J: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_j;
                w_ram_wdata = r_a;
            end
            rc4kx_pkg::S_PG_RD_T: begin
                w_ram_addr = AW'(r_a + r_b);
            end
            rc4kx_pkg::S_PG_OUT: begin
                // keystream byte is on the read port now
                if (r_op.kind == rc4kx_pkg::OP_START) begin
                    n_cnt = r_cnt - rc4kx_pkg::DROP_W'(1);
                end else begin
                    n_res_byte = r_op.data ^ w_ram_rdata;
                end
            end
            rc4kx_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_res_byte;
                    n_ostat  = r_res_stat;
                    n_olast  = r_res_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rc4kx_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_fill   <= '0;
            r_keyed  <= 1'b0;
            for (int e = 0; e < rc4kx_pkg::MAX_KEY_BYTES; e++) begin
                r_key[e] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_i      <= n_i;
            r_j      <= n_j;
            r_fill   <= n_fill;
            r_keyed  <= n_keyed;
            if (w_key_we) begin
                r_key[r_fill[rc4kx_pkg::KEY_IDX_W-1:0]] <= i_q_op.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op <= i_q_op;
        end
        r_n        <= n_n;
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_res_byte <= n_res_byte;
        r_res_stat <= n_res_stat;
        r_res_last <= n_res_last;
        r_obyte    <= n_obyte;
        r_ostat    <= n_ostat;
        r_olast    <= n_olast;
    end

endmodule
`default_nettype wire

// ===== sv/rc4_keystream_xor.sv =====
// channel  | dir | tdata                                   | tuser      | tlast
// s        | in  | data_byte, key_length, drop_count       | cmd        | final_byte
// m        | out | out_byte                                | status     | last
//
// a key load or an unkeyed data byte goes from idle straight to the result; a keyed data byte
// is sequenced on the single-port state table ram (two reads, two swap writes, one output read)
// a start runs an identity fill, 256 schedule steps (read n, read j, write n, write j), then
// the same ram sequence as a keyed data byte for each dropped keystream byte
// reset is synchronous, active low; the state table is not cleared
// a two-entry queue sits between decode and the ram sequencer; a result waiting in
// the output register stalls only the sequencer, the queue keeps taking transfers until full
`default_nettype none
module rc4_keystream_xor (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [7:0] data_byte, [12:8] key_length, [28:13] drop_count, [31:29] zero
    input  wire logic [rc4kx_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] cmd
    input  wire logic [rc4kx_pkg::CMD_W-1:0]      i_s_tuser,
    input  wire logic                             i_s_tlast,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [7:0] out_byte
    output logic [rc4kx_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // [2:0] status
    output logic [rc4kx_pkg::STAT_W-1:0]          o_m_tuser,
    output logic                                  o_m_tlast
);

    logic           w_q_valid;
    logic           w_q_ready;
    rc4kx_pkg::t_op w_q_op;

    rc4kx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_op     (w_q_op)
    );

    rc4kx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_ready  (w_q_ready),
        .i_q_op     (w_q_op),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= rc4kx_pkg::STAT_UNKEYED))
        else $error("status code out of range");

    a_non_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == rc4kx_pkg::STAT_KEY_STORED
                     || o_m_tuser == rc4kx_pkg::STAT_KEY_FULL
                     || o_m_tuser == rc4kx_pkg::STAT_SCHEDULED))
        |-> (o_m_tdata == '0 && !o_m_tlast))
        else $error("non-data result carries payload");

    a_one_op_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_q_ready) |=> !w_q_ready)
        else $error("sequencer took a second op before finishing");

endmodule
`default_nettype wire
